>>> rtl/core/sle_pkg.sv
// Shared constants, codes and types of the sequential list engine.
package sle_pkg;

  localparam int unsigned DEPTH      = 128;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);

  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;

  // common width for position and count compares
  localparam int unsigned CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELAT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELVAL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [POS_W-1:0] found_position;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] list_length;
    logic             is_empty;
  } res_t;

  localparam int unsigned RES_BITS  = $bits(res_t);
  localparam int unsigned OUT_TDW   = ((RES_BITS + 7) / 8) * 8;
  localparam int unsigned IN_BITS   = POS_W + VAL_W;
  localparam int unsigned IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned IN_TUW    = 8;

endpackage

>>> rtl/core/sle_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned WORDS = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(WORDS)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/sle_ctrl.sv
// Command sequencer: streams the store through the RAM for search, shift and sort.
module sle_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  logic [sle_pkg::CMD_W-1:0]           cmd_i,
  input  logic [sle_pkg::POS_W-1:0]           pos_i,
  input  logic [sle_pkg::VAL_W-1:0]           val_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output sle_pkg::res_t                       res_o,
  output logic                                ram_we_o,
  output logic [sle_pkg::AW-1:0]              ram_waddr_o,
  output logic [sle_pkg::DATA_WIDTH-1:0]      ram_wdata_o,
  output logic                                ram_re_o,
  output logic [sle_pkg::AW-1:0]              ram_raddr_o,
  input  logic [sle_pkg::DATA_WIDTH-1:0]      ram_rdata_i
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_STREAM, S_TAIL, S_DONE} state_e;

  localparam int unsigned DW = sle_pkg::DATA_WIDTH;
  localparam int unsigned AW = sle_pkg::AW;
  localparam int unsigned CW = sle_pkg::CW;
  localparam int unsigned XW = sle_pkg::CMP_W;

  state_e                    state_q, state_d;
  logic [sle_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [AW-1:0]             pos0_q, pos0_d;   // zero-based position
  logic [DW-1:0]             val_q, val_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             rd_idx_q, rd_idx_d;
  logic [CW-1:0]             rd_left_q, rd_left_d;
  logic                      pv_q, pv_d;
  logic [AW-1:0]             pidx_q, pidx_d;
  logic [CW-1:0]             wp_q, wp_d;
  logic [DW-1:0]             carry_q, carry_d;
  logic                      swapped_q, swapped_d;
  logic [CW-1:0]             found_q, found_d;
  logic [sle_pkg::ST_W-1:0]  status_q, status_d;
  logic [DW-1:0]             rdval_q, rdval_d;

  logic [XW-1:0] posx, cntx;
  logic          issue;

  assign posx = XW'(pos_i);
  assign cntx = XW'(cnt_q);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o                = '0;
    res_o.read_value     = sle_pkg::VAL_W'($signed(rdval_q));
    res_o.found_position = sle_pkg::POS_W'(found_q);
    res_o.status         = status_q;
    res_o.list_length    = sle_pkg::POS_W'(cnt_q);
    res_o.is_empty       = (cnt_q == '0);
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pos0_d    = pos0_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    rd_left_d = rd_left_q;
    pv_d      = 1'b0;
    pidx_d    = rd_idx_q;
    wp_d      = wp_q;
    carry_d   = carry_q;
    swapped_d = swapped_q;
    found_d   = found_q;
    status_d  = status_q;
    rdval_d   = rdval_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_idx_q;

    issue = (state_q == S_STREAM) && (rd_left_q != '0) &&
            !((cmd_q == sle_pkg::CMD_LOCATE) && (found_q != '0));

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          pos0_d    = AW'(pos_i - 1'b1);
          val_d     = DW'(val_i);
          status_d  = sle_pkg::ST_OK;
          found_d   = '0;
          rdval_d   = '0;
          wp_d      = '0;
          swapped_d = 1'b0;
          rd_idx_d  = '0;
          rd_left_d = cnt_q;
          state_d   = S_DONE;
          unique case (cmd_i)
            sle_pkg::CMD_GET: begin
              if (posx >= XW'(1) && posx <= cntx) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(pos_i - 1'b1);
                state_d     = S_READ;
              end else begin
                status_d = sle_pkg::ST_BAD_POS;
              end
            end
            sle_pkg::CMD_LOCATE, sle_pkg::CMD_DELVAL: begin
              state_d = S_STREAM;
            end
            sle_pkg::CMD_INSERT: begin
              if (cntx >= XW'(sle_pkg::DEPTH)) begin
                status_d = sle_pkg::ST_FULL;
              end else if (posx < XW'(1) || posx > cntx + XW'(1)) begin
                status_d = sle_pkg::ST_BAD_POS;
              end else begin
                // walk down from the last element to the insert slot
                rd_idx_d  = AW'(cnt_q - 1'b1);
                rd_left_d = CW'(cntx - posx + XW'(1));
                state_d   = S_STREAM;
              end
            end
            sle_pkg::CMD_DELAT: begin
              if (posx >= XW'(1) && posx <= cntx) begin
                rd_idx_d  = AW'(pos_i);
                rd_left_d = CW'(cntx - posx);
                state_d   = S_STREAM;
              end else begin
                status_d = sle_pkg::ST_BAD_POS;
              end
            end
            sle_pkg::CMD_SORT: begin
              if (cnt_q > CW'(1)) begin
                state_d = S_STREAM;
              end
            end
            sle_pkg::CMD_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        rdval_d = ram_rdata_i;
        state_d = S_DONE;
      end

      S_STREAM: begin
        if (issue) begin
          ram_re_o  = 1'b1;
          pv_d      = 1'b1;
          pidx_d    = rd_idx_q;
          rd_left_d = rd_left_q - 1'b1;
          if (cmd_q == sle_pkg::CMD_INSERT) begin
            rd_idx_d = rd_idx_q - 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (pv_q) begin
          unique case (cmd_q)
            sle_pkg::CMD_LOCATE: begin
              if (found_q == '0 && ram_rdata_i == val_q) begin
                found_d = CW'(pidx_q) + 1'b1;
              end
            end
            sle_pkg::CMD_DELVAL: begin
              // compaction: survivors go to the write pointer, which trails the reads
              if (ram_rdata_i != val_q) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = AW'(wp_q);
                ram_wdata_o = ram_rdata_i;
                wp_d        = wp_q + 1'b1;
              end
            end
            sle_pkg::CMD_INSERT: begin
              ram_we_o    = 1'b1;
              ram_waddr_o = pidx_q + 1'b1;
              ram_wdata_o = ram_rdata_i;
            end
            sle_pkg::CMD_DELAT: begin
              ram_we_o    = 1'b1;
              ram_waddr_o = pidx_q - 1'b1;
              ram_wdata_o = ram_rdata_i;
            end
            default: begin
              // sort: one bubble pass, carry holds the running maximum
              if (pidx_q == '0) begin
                carry_d = ram_rdata_i;
              end else if ($signed(carry_q) > $signed(ram_rdata_i)) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = pidx_q - 1'b1;
                ram_wdata_o = ram_rdata_i;
                swapped_d   = 1'b1;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = pidx_q - 1'b1;
                ram_wdata_o = carry_q;
                carry_d     = ram_rdata_i;
              end
            end
          endcase
        end
        if (!issue && !pv_q) begin
          unique case (cmd_q)
            sle_pkg::CMD_LOCATE: begin
              if (found_q == '0) begin
                status_d = sle_pkg::ST_NOTFOUND;
              end
              state_d = S_DONE;
            end
            sle_pkg::CMD_DELVAL: begin
              if (wp_q == cnt_q) begin
                status_d = sle_pkg::ST_NOTFOUND;
              end
              cnt_d   = wp_q;
              state_d = S_DONE;
            end
            sle_pkg::CMD_DELAT: begin
              cnt_d   = cnt_q - 1'b1;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_TAIL;
            end
          endcase
        end
      end

      S_TAIL: begin
        ram_we_o = 1'b1;
        if (cmd_q == sle_pkg::CMD_INSERT) begin
          ram_waddr_o = pos0_q;
          ram_wdata_o = val_q;
          cnt_d       = cnt_q + 1'b1;
          state_d     = S_DONE;
        end else begin
          ram_waddr_o = AW'(cnt_q - 1'b1);
          ram_wdata_o = carry_q;
          if (swapped_q) begin
            swapped_d = 1'b0;
            rd_idx_d  = '0;
            rd_left_d = cnt_q;
            state_d   = S_STREAM;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      swapped_q <= 1'b0;
      found_q   <= '0;
      status_q  <= sle_pkg::ST_OK;
      rd_left_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      swapped_q <= swapped_d;
      found_q   <= found_d;
      status_q  <= status_d;
      rd_left_q <= rd_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pos0_q   <= pos0_d;
    val_q    <= val_d;
    rd_idx_q <= rd_idx_d;
    pidx_q   <= pidx_d;
    wp_q     <= wp_d;
    carry_q  <= carry_d;
    rdval_q  <= rdval_d;
  end

endmodule

>>> rtl/core/sequential_list_engine_core.sv
// Top level of the sequential list engine: stream ports, sequencer, element RAM.
// Get reads one element; locate and delete-value stream the list; delete at and insert
// shift the tail of the list; sort is bubble passes, up to count passes, until one makes
// no swap. Clear and bad commands go straight to the result.
// One command at a time; the output register frees the sequencer.
// Reset empties the list at once; RAM contents are not cleared and never read unwritten.
module sequential_list_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] position, [39:8] value
  input  logic [sle_pkg::IN_TDW-1:0]  s_axis_tdata,
  // [2:0] cmd
  input  logic [sle_pkg::IN_TUW-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] read_value, [39:32] found_position, [41:40] status,
  // [49:42] list_length, [50] is_empty
  output logic [sle_pkg::OUT_TDW-1:0] m_axis_tdata
);

  logic                               ram_we, ram_re;
  logic [sle_pkg::AW-1:0]             ram_waddr, ram_raddr;
  logic [sle_pkg::DATA_WIDTH-1:0]     ram_wdata, ram_rdata;
  logic                               res_valid, res_ready;
  sle_pkg::res_t                      res;
  logic                               m_valid_q;
  sle_pkg::res_t                      m_res_q;

  sle_ram #(
    .WIDTH (sle_pkg::DATA_WIDTH),
    .WORDS (sle_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (s_axis_tuser[sle_pkg::CMD_W-1:0]),
    .pos_i       (s_axis_tdata[sle_pkg::POS_W-1:0]),
    .val_i       (s_axis_tdata[sle_pkg::IN_BITS-1:sle_pkg::POS_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(sle_pkg::OUT_TDW - sle_pkg::RES_BITS){1'b0}},
                          m_res_q.is_empty, m_res_q.list_length, m_res_q.status,
                          m_res_q.found_position, m_res_q.read_value};

`ifndef SYNTHESIS
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer took a second command while busy");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_res_q.is_empty == (m_res_q.list_length == '0)))
    else $error("empty flag disagrees with length");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_res_q.status == sle_pkg::ST_FULL) |->
    (m_res_q.list_length == sle_pkg::POS_W'(sle_pkg::DEPTH)))
    else $error("full status with room left");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_res_q.list_length <= sle_pkg::POS_W'(sle_pkg::DEPTH)))
    else $error("length beyond capacity");
`endif

endmodule
